### rtl/hsjg_pkg.sv
// Shared types and constants of the Halton sub-pixel jitter generator.
// Used by hsjg_div, halton_subpixel_jitter_generator and the testbench; depends on nothing.
`default_nettype none

package hsjg_pkg;

    // Field widths
    localparam int EXT_W        = 15;
    localparam int JIT_W        = 16;
    localparam int OFF_W        = 26;
    localparam int CNT_W        = 32;
    localparam int PHASE_W      = 31;
    localparam int FRAME_W      = 64;
    localparam int OFF_FRAC_BITS = 24;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RENDER_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RENDER_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 2'd3;

    // Phase count: ceil(8 * ow^2 / rw^2), clamped to 2^31
    localparam int PHASE_SCALE_SH = 3;
    localparam int CNT_Q_BITS     = 34;
    localparam logic [63:0] PHASE_LIMIT = 64'h0000_0000_8000_0000;

    // floor(n / 3) = (n * RECIP3) >> 33 for any 32-bit n
    localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
    localparam int          RECIP3_SH = 33;
    localparam int          DIGIT_W   = 32;

    // Shared divider
    localparam int DIV_DVD_W = 64;
    localparam int DIV_DSR_W = 34;
    localparam int DIV_CNT_W = 7;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] q_bits;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/hsjg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on hsjg_pkg for widths and the control/status structs.
`default_nettype none

module hsjg_div (
    input  wire  logic                                aclk,
    input  wire  logic                                aresetn,
    input  wire  hsjg_pkg::div_ctrl_t                 ctrl,
    input  wire  logic [hsjg_pkg::DIV_DVD_W-1:0]      dividend,
    input  wire  logic [hsjg_pkg::DIV_DSR_W-1:0]      divisor,
    output hsjg_pkg::div_stat_t                       stat,
    output logic [hsjg_pkg::DIV_DVD_W-1:0]            quotient,
    output logic [hsjg_pkg::DIV_DSR_W-1:0]            remainder
);

    localparam int DVD_W = hsjg_pkg::DIV_DVD_W;
    localparam int DSR_W = hsjg_pkg::DIV_DSR_W;
    localparam int CW    = hsjg_pkg::DIV_CNT_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W-1:0] rem_init;
    logic [DVD_W-1:0] quo_init;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] diff;
    logic             ge;
    logic [DSR_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    // Caller guarantees quotient < 2^q_bits, so the upper part is already a remainder
    always_comb begin
        rem_init = DSR_W'(dividend >> ctrl.q_bits);
        quo_init = dividend << (CW'(DVD_W) - ctrl.q_bits);
    end

    // One shift-subtract step
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dsr_reg};
        ge       = ~diff[DSR_W+1];
        rem_next = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.q_bits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= rem_init;
            quo_reg <= quo_init;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat      = '{busy: busy_reg, done: done_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/halton_subpixel_jitter_generator.sv
// Halton (2,3) sub-pixel jitter generator, top level.
// Depends on hsjg_pkg and hsjg_div.
//
// Usage:
//   Input channel s_valid/s_ready carries a 64-bit frame number. Result channel
//   m_valid/m_ready carries status, jitter x/y (signed, JITTER_FRAC_BITS
//   fraction bits), clip-space offsets x/y (signed, 24 fraction bits), the
//   phase count and the phase index. One result per transaction.
//   Extents are written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequencing:
//   One transaction at a time. A valid one puts its result in the output register
//   once the shared one-bit-per-cycle divider (six divisions: 34, 64, two of
//   JITTER_FRAC_BITS+1 and two of 26 steps) and the base-3 digit loop on the
//   shared multiplier (up to 20 digits) are through. Invalid extents go straight
//   to the output state. s_ready is back with the result; it is high whenever the
//   sequencer is idle, also while a result waits.
// Reset: aresetn (synchronous, active low) clears all extents to zero, the
//   sequencer and m_valid. If m_ready is low the result stays in the output
//   register; a finished computation then waits until that register frees.
`default_nettype none

module halton_subpixel_jitter_generator #(
    parameter int MAX_EXTENT       = 16384,
    parameter int JITTER_FRAC_BITS = 16,
    parameter int MIN_PHASES       = 8
) (
    input  wire  logic                                aclk,
    input  wire  logic                                aresetn,
    // configuration
    input  wire  logic                                cfg_we,
    input  wire  logic [hsjg_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire  logic [hsjg_pkg::EXT_W-1:0]          cfg_wdata,
    // input channel
    input  wire  logic                                s_valid,
    output logic                                      s_ready,
    input  wire  logic [hsjg_pkg::FRAME_W-1:0]        s_frame_number,
    // result channel
    output logic                                      m_valid,
    input  wire  logic                                m_ready,
    output logic                                      m_status,
    output logic signed [hsjg_pkg::JIT_W-1:0]         m_jitter_x,
    output logic signed [hsjg_pkg::JIT_W-1:0]         m_jitter_y,
    output logic signed [hsjg_pkg::OFF_W-1:0]         m_offset_x,
    output logic signed [hsjg_pkg::OFF_W-1:0]         m_offset_y,
    output logic [hsjg_pkg::CNT_W-1:0]                m_phase_count,
    output logic [hsjg_pkg::PHASE_W-1:0]              m_phase_index
);

    localparam int JF         = JITTER_FRAC_BITS;
    localparam int EXT_W      = hsjg_pkg::EXT_W;
    localparam int OFF_W      = hsjg_pkg::OFF_W;
    localparam int CNT_W      = hsjg_pkg::CNT_W;
    localparam int PHASE_W    = hsjg_pkg::PHASE_W;
    localparam int DW         = hsjg_pkg::DIGIT_W;
    localparam int DVD_W      = hsjg_pkg::DIV_DVD_W;
    localparam int DSR_W      = hsjg_pkg::DIV_DSR_W;
    localparam int CW         = hsjg_pkg::DIV_CNT_W;
    localparam int OFF_SHIFT  = hsjg_pkg::OFF_FRAC_BITS - JITTER_FRAC_BITS + 2;
    localparam int OFF_Q_BITS = hsjg_pkg::OFF_FRAC_BITS + 2;
    localparam int SQ_W       = 2 * EXT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SQR, S_SQO,
        S_CNT_GO, S_CNT_WAIT, S_PH_GO, S_PH_WAIT,
        S_DIG_MUL, S_DIG_UPD,
        S_HX_GO, S_HX_WAIT, S_HY_GO, S_HY_WAIT,
        S_OX_GO, S_OX_WAIT, S_OY_GO, S_OY_WAIT,
        S_OUT
    } state_t;

    // Configuration registers
    logic [EXT_W-1:0] rw_reg, rh_reg, ow_reg, oh_reg;

    // Sequencer and working registers
    state_t                  state_reg;
    logic [DVD_W-1:0]        frame_reg;
    logic [2*DW-1:0]         prod_reg;
    logic [SQ_W-1:0]         rw2_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [PHASE_W-1:0]      phase_reg;
    logic                    status_reg;
    logic [DW-1:0]           n2_reg, num2_reg, n3_reg, num3_reg, den3_reg;
    logic [DW:0]             den2_reg;
    logic signed [JF-1:0]    jx_reg, jy_reg;
    logic signed [OFF_W-1:0] ox_reg, oy_reg;

    // Output register
    logic                       m_valid_reg;
    logic                       m_status_reg;
    logic signed [15:0]         m_jitter_x_reg, m_jitter_y_reg;
    logic signed [OFF_W-1:0]    m_offset_x_reg, m_offset_y_reg;
    logic [CNT_W-1:0]           m_phase_count_reg;
    logic [PHASE_W-1:0]         m_phase_index_reg;

    // Shared units
    logic [DW-1:0]              mul_a, mul_b;
    hsjg_pkg::div_ctrl_t        div_ctrl;
    hsjg_pkg::div_stat_t        div_stat;
    logic [DVD_W-1:0]           div_dividend;
    logic [DSR_W-1:0]           div_divisor;
    logic [DVD_W-1:0]           div_quo;
    logic [DSR_W-1:0]           div_rem;

    logic                       in_fire;
    logic                       ext_ok;
    logic [DVD_W-1:0]           cnt_raw;
    logic [CNT_W-1:0]           cnt_clamped;
    logic [DW-2:0]              q3;
    logic [1:0]                 q3_x3;
    logic [1:0]                 d3;
    logic [DW-1:0]              num3_step, den3_step;
    logic [JF:0]                rq;
    logic [JF-1:0]              jit_sat;
    logic [JF-1:0]              abs_x, abs_y;
    logic [OFF_W-1:0]           oq, oq_neg;

    assign in_fire = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // Extent check: nonzero and not above the limit
    assign ext_ok = (rw_reg != '0) && (17'(rw_reg) <= 17'(MAX_EXTENT))
                 && (rh_reg != '0) && (17'(rh_reg) <= 17'(MAX_EXTENT))
                 && (ow_reg != '0) && (17'(ow_reg) <= 17'(MAX_EXTENT))
                 && (oh_reg != '0) && (17'(oh_reg) <= 17'(MAX_EXTENT));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rw_reg <= '0;
            rh_reg <= '0;
            ow_reg <= '0;
            oh_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                hsjg_pkg::REG_RENDER_WIDTH:  rw_reg <= cfg_wdata;
                hsjg_pkg::REG_RENDER_HEIGHT: rh_reg <= cfg_wdata;
                hsjg_pkg::REG_OUTPUT_WIDTH:  ow_reg <= cfg_wdata;
                hsjg_pkg::REG_OUTPUT_HEIGHT: oh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared multiplier: squares of the render and output widths, then n3 * (1/3)
    always_comb begin
        case (state_reg)
            S_SQR: begin
                mul_a = DW'(rw_reg);
                mul_b = DW'(rw_reg);
            end
            S_SQO: begin
                mul_a = DW'(ow_reg);
                mul_b = DW'(ow_reg);
            end
            default: begin
                mul_a = n3_reg;
                mul_b = hsjg_pkg::RECIP3;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= (2*DW)'(mul_a) * (2*DW)'(mul_b);
    end

    // Divider operand select
    always_comb begin
        div_ctrl     = '{start: 1'b0, q_bits: '0};
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            S_CNT_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(hsjg_pkg::CNT_Q_BITS)};
                div_dividend = (prod_reg << hsjg_pkg::PHASE_SCALE_SH)
                             + DVD_W'(rw2_reg) - DVD_W'(1);
                div_divisor  = DSR_W'(rw2_reg);
            end
            S_PH_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(DVD_W)};
                div_dividend = frame_reg;
                div_divisor  = DSR_W'(count_reg);
            end
            S_HX_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(JF + 1)};
                div_dividend = (DVD_W'(num2_reg) << (JF + 1)) + DVD_W'(den2_reg);
                div_divisor  = DSR_W'(den2_reg) << 1;
            end
            S_HY_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(JF + 1)};
                div_dividend = (DVD_W'(num3_reg) << (JF + 1)) + DVD_W'(den3_reg);
                div_divisor  = DSR_W'(den3_reg) << 1;
            end
            S_OX_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(OFF_Q_BITS)};
                div_dividend = (DVD_W'(abs_x) << OFF_SHIFT) + DVD_W'(rw_reg);
                div_divisor  = DSR_W'(rw_reg) << 1;
            end
            S_OY_GO: begin
                div_ctrl     = '{start: 1'b1, q_bits: CW'(OFF_Q_BITS)};
                div_dividend = (DVD_W'(abs_y) << OFF_SHIFT) + DVD_W'(rh_reg);
                div_divisor  = DSR_W'(rh_reg) << 1;
            end
            default: ;
        endcase
    end

    hsjg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Phase count clamp
    always_comb begin
        cnt_raw = div_quo;
        if (cnt_raw < DVD_W'(MIN_PHASES)) begin
            cnt_clamped = CNT_W'(MIN_PHASES);
        end else if (cnt_raw > hsjg_pkg::PHASE_LIMIT) begin
            cnt_clamped = CNT_W'(hsjg_pkg::PHASE_LIMIT);
        end else begin
            cnt_clamped = cnt_raw[CNT_W-1:0];
        end
    end

    // Base-3 digit: q = n / 3 from the product, digit = n - 3q (low bits suffice)
    always_comb begin
        q3        = prod_reg[hsjg_pkg::RECIP3_SH +: DW-1];
        q3_x3     = {q3[0], 1'b0} + q3[1:0];
        d3        = n3_reg[1:0] - q3_x3;
        num3_step = (num3_reg << 1) + num3_reg + DW'(d3);
        den3_step = (den3_reg << 1) + den3_reg;
    end

    // Rounded radical inverse minus one half: flip the top bit, saturate just below +1/2
    always_comb begin
        rq      = div_quo[JF:0];
        jit_sat = rq[JF] ? {1'b0, {(JF-1){1'b1}}} : {~rq[JF-1], rq[JF-2:0]};
    end

    // Offset magnitudes and signed quotient
    always_comb begin
        abs_x  = jx_reg[JF-1] ? JF'(-jx_reg) : JF'(jx_reg);
        abs_y  = jy_reg[JF-1] ? JF'(-jy_reg) : JF'(jy_reg);
        oq     = div_quo[OFF_W-1:0];
        oq_neg = ~oq + OFF_W'(1);
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        frame_reg  <= s_frame_number;
                        status_reg <= ~ext_ok;
                        if (ext_ok) begin
                            state_reg <= S_SQR;
                        end else begin
                            jx_reg    <= '0;
                            jy_reg    <= '0;
                            ox_reg    <= '0;
                            oy_reg    <= '0;
                            count_reg <= '0;
                            phase_reg <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SQR: state_reg <= S_SQO;
                S_SQO: begin
                    rw2_reg   <= prod_reg[SQ_W-1:0];
                    state_reg <= S_CNT_GO;
                end
                S_CNT_GO: state_reg <= S_CNT_WAIT;
                S_CNT_WAIT: begin
                    if (div_stat.done) begin
                        count_reg <= cnt_clamped;
                        state_reg <= S_PH_GO;
                    end
                end
                S_PH_GO: state_reg <= S_PH_WAIT;
                S_PH_WAIT: begin
                    if (div_stat.done) begin
                        phase_reg <= div_rem[PHASE_W-1:0];
                        n2_reg    <= DW'(div_rem[PHASE_W-1:0]) + DW'(1);
                        n3_reg    <= DW'(div_rem[PHASE_W-1:0]) + DW'(1);
                        num2_reg  <= '0;
                        den2_reg  <= (DW+1)'(1);
                        num3_reg  <= '0;
                        den3_reg  <= DW'(1);
                        state_reg <= S_DIG_MUL;
                    end
                end
                // base 2 steps every cycle, base 3 only in S_DIG_UPD
                S_DIG_MUL: begin
                    if (n2_reg == '0 && n3_reg == '0) begin
                        state_reg <= S_HX_GO;
                    end else begin
                        if (n2_reg != '0) begin
                            num2_reg <= {num2_reg[DW-2:0], n2_reg[0]};
                            den2_reg <= den2_reg << 1;
                            n2_reg   <= n2_reg >> 1;
                        end
                        state_reg <= S_DIG_UPD;
                    end
                end
                S_DIG_UPD: begin
                    if (n2_reg != '0) begin
                        num2_reg <= {num2_reg[DW-2:0], n2_reg[0]};
                        den2_reg <= den2_reg << 1;
                        n2_reg   <= n2_reg >> 1;
                    end
                    if (n3_reg != '0) begin
                        num3_reg <= num3_step;
                        den3_reg <= den3_step;
                        n3_reg   <= DW'(q3);
                    end
                    state_reg <= S_DIG_MUL;
                end
                S_HX_GO: state_reg <= S_HX_WAIT;
                S_HX_WAIT: begin
                    if (div_stat.done) begin
                        jx_reg    <= jit_sat;
                        state_reg <= S_HY_GO;
                    end
                end
                S_HY_GO: state_reg <= S_HY_WAIT;
                S_HY_WAIT: begin
                    if (div_stat.done) begin
                        jy_reg    <= jit_sat;
                        state_reg <= S_OX_GO;
                    end
                end
                S_OX_GO: state_reg <= S_OX_WAIT;
                S_OX_WAIT: begin
                    if (div_stat.done) begin
                        ox_reg    <= jx_reg[JF-1] ? oq_neg : oq;
                        state_reg <= S_OY_GO;
                    end
                end
                S_OY_GO: state_reg <= S_OY_WAIT;
                S_OY_WAIT: begin
                    if (div_stat.done) begin
                        oy_reg    <= jy_reg[JF-1] ? oq : oq_neg;
                        state_reg <= S_OUT;
                    end
                end
                // hand over once the output register is free
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= status_reg;
                        m_jitter_x_reg    <= 16'(jx_reg);
                        m_jitter_y_reg    <= 16'(jy_reg);
                        m_offset_x_reg    <= ox_reg;
                        m_offset_y_reg    <= oy_reg;
                        m_phase_count_reg <= count_reg;
                        m_phase_index_reg <= phase_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_jitter_x    = m_jitter_x_reg;
    assign m_jitter_y    = m_jitter_y_reg;
    assign m_offset_x    = m_offset_x_reg;
    assign m_offset_y    = m_offset_y_reg;
    assign m_phase_count = m_phase_count_reg;
    assign m_phase_index = m_phase_index_reg;

`ifndef SYNTHESIS
    // Divider is never restarted mid-division
    ap_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Division results only arrive while the sequencer waits for them
    ap_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_CNT_WAIT || state_reg == S_PH_WAIT
                        || state_reg == S_HX_WAIT || state_reg == S_HY_WAIT
                        || state_reg == S_OX_WAIT || state_reg == S_OY_WAIT))
        else $error("divider finished outside a wait state");

    // Invalid extents give an all-zero result
    ap_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_jitter_x == '0 && m_jitter_y == '0
            && m_offset_x == '0 && m_offset_y == '0
            && m_phase_count == '0 && m_phase_index == '0))
        else $error("invalid result carries nonzero fields");

    // Phase index lies inside a phase count of at least the minimum
    ap_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status) |-> ({1'b0, m_phase_index} < m_phase_count
            && m_phase_count >= CNT_W'(MIN_PHASES)))
        else $error("phase index or count out of range");

    // One transaction at a time
    ap_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for halton_subpixel_jitter_generator: an in-bench predictor of status, jitter,
// offsets, phase count and phase index checked against every result transaction.
// Depends on hsjg_pkg and the RTL of the generator only.
`timescale 1ns / 1ps

module tb;

    localparam int EXT_W            = hsjg_pkg::EXT_W;
    localparam int JIT_W            = hsjg_pkg::JIT_W;
    localparam int OFF_W            = hsjg_pkg::OFF_W;
    localparam int CNT_W            = hsjg_pkg::CNT_W;
    localparam int PHASE_W          = hsjg_pkg::PHASE_W;
    localparam int FRAME_W          = hsjg_pkg::FRAME_W;
    localparam int REG_IDX_W        = hsjg_pkg::REG_IDX_W;
    localparam int MAX_EXTENT       = 16384;
    localparam int JIT_FRAC         = 16;
    localparam int MIN_PHASES       = 8;
    localparam int EXTENT_ALL_ONES  = (1 << EXT_W) - 1;
    localparam int RANDOM_ITEMS     = 400;
    localparam int SETTLE_CYCLES    = 250;
    localparam longint TIMEOUT_NS   = 4_000_000;

    typedef struct packed {
        logic                      status;
        logic signed [JIT_W-1:0]   jitter_x;
        logic signed [JIT_W-1:0]   jitter_y;
        logic signed [OFF_W-1:0]   offset_x;
        logic signed [OFF_W-1:0]   offset_y;
        logic [CNT_W-1:0]          phase_count;
        logic [PHASE_W-1:0]        phase_index;
    } jitter_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [EXT_W-1:0]       cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [FRAME_W-1:0]     s_frame_number;
    logic                   m_valid;
    logic                   m_ready = 1'b1;
    logic                   m_status;
    logic signed [JIT_W-1:0] m_jitter_x;
    logic signed [JIT_W-1:0] m_jitter_y;
    logic signed [OFF_W-1:0] m_offset_x;
    logic signed [OFF_W-1:0] m_offset_y;
    logic [CNT_W-1:0]       m_phase_count;
    logic [PHASE_W-1:0]     m_phase_index;

    // shadow copy of the extent registers
    logic [EXT_W-1:0]       extent [4];

    jitter_result_t         pending_jitter [$];
    logic [FRAME_W-1:0]     pending_frame [$];
    int                     error_count = 0;
    int                     burst_left = 0;
    bit                     sender_idles = 1'b1;
    int                     ready_left = 0;
    int                     ready_mode = 0;

    halton_subpixel_jitter_generator #(
        .MAX_EXTENT       (MAX_EXTENT),
        .JITTER_FRAC_BITS (JIT_FRAC),
        .MIN_PHASES       (MIN_PHASES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_jitter_x     (m_jitter_x),
        .m_jitter_y     (m_jitter_y),
        .m_offset_x     (m_offset_x),
        .m_offset_y     (m_offset_y),
        .m_phase_count  (m_phase_count),
        .m_phase_index  (m_phase_index)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic bit extent_ok(input logic [EXT_W-1:0] e);
        return e != 0 && e <= MAX_EXTENT;
    endfunction

    function automatic bit extents_valid();
        return extent_ok(extent[hsjg_pkg::REG_RENDER_WIDTH]) &&
               extent_ok(extent[hsjg_pkg::REG_RENDER_HEIGHT]) &&
               extent_ok(extent[hsjg_pkg::REG_OUTPUT_WIDTH]) &&
               extent_ok(extent[hsjg_pkg::REG_OUTPUT_HEIGHT]);
    endfunction

    // ceil(8*ow^2/rw^2), at least MIN_PHASES, at most 2^31; zero when invalid
    function automatic longint unsigned phase_cycle_len();
        longint unsigned rw, ow, rw2, ow2, cnt;
        if (!extents_valid())
            return 0;
        rw  = extent[hsjg_pkg::REG_RENDER_WIDTH];
        ow  = extent[hsjg_pkg::REG_OUTPUT_WIDTH];
        rw2 = rw * rw;
        ow2 = ow * ow;
        cnt = ((ow2 << hsjg_pkg::PHASE_SCALE_SH) + rw2 - 1) / rw2;
        if (cnt < 64'(MIN_PHASES))
            cnt = 64'(MIN_PHASES);
        if (cnt > hsjg_pkg::PHASE_LIMIT)
            cnt = hsjg_pkg::PHASE_LIMIT;
        return cnt;
    endfunction

    // rounded radical inverse of n in the given base, re-centered, saturated
    function automatic longint halton_jitter_fx(input longint unsigned n,
                                                input longint unsigned base);
        longint unsigned num, den, r;
        longint j, top;
        num = 0;
        den = 1;
        top = longint'(1) << (JIT_FRAC - 1);
        while (n > 0) begin
            num = num * base + (n % base);
            den = den * base;
            n   = n / base;
        end
        r = ((num << (JIT_FRAC + 1)) + den) / (2 * den);
        j = longint'(r) - top;
        if (j > top - 1)
            j = top - 1;
        return j;
    endfunction

    // 2*j/e at 24 fraction bits, rounded half away from zero
    function automatic longint clip_offset_fx(input longint j, input longint unsigned e);
        longint unsigned mag, q;
        longint aj;
        aj  = (j < 0) ? -j : j;
        mag = longint'(aj) << (hsjg_pkg::OFF_FRAC_BITS - JIT_FRAC + 1);
        q   = (2 * mag + e) / (2 * e);
        return (j < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic jitter_result_t jitter_for_frame(input logic [FRAME_W-1:0] frame);
        jitter_result_t res;
        longint unsigned cnt, phase;
        longint jx, jy, ox, oy;
        res = '0;
        if (!extents_valid()) begin
            res.status = 1'b1;
            return res;
        end
        cnt   = phase_cycle_len();
        phase = frame % cnt;
        jx = halton_jitter_fx(phase + 1, 2);
        jy = halton_jitter_fx(phase + 1, 3);
        ox = clip_offset_fx(jx, extent[hsjg_pkg::REG_RENDER_WIDTH]);
        oy = -clip_offset_fx(jy, extent[hsjg_pkg::REG_RENDER_HEIGHT]);
        res.jitter_x    = jx[JIT_W-1:0];
        res.jitter_y    = jy[JIT_W-1:0];
        res.offset_x    = ox[OFF_W-1:0];
        res.offset_y    = oy[OFF_W-1:0];
        res.phase_count = cnt[CNT_W-1:0];
        res.phase_index = phase[PHASE_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [EXT_W-1:0] pick_extent();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return EXT_W'($urandom_range(MAX_EXTENT + 1, EXTENT_ALL_ONES));
            2, 3:    return EXT_W'(1);
            4, 5:    return EXT_W'(MAX_EXTENT);
            6, 7, 8, 9, 10: return EXT_W'($urandom_range(1, 64));
            default: return EXT_W'($urandom_range(1, MAX_EXTENT));
        endcase
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        longint unsigned cnt;
        cnt = phase_cycle_len();
        case ($urandom_range(0, 4))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 64));
            2:       return ~64'($urandom_range(0, 64));
            // around a wrap of the jitter cycle
            3:       return (cnt != 0) ? cnt * $urandom_range(1, 1000) + $urandom_range(0, 2) - 1
                                       : {$urandom, $urandom};
            default: return 64'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // one frame transaction; while sender_idles is set, the sender may idle between bursts
    task automatic send_frame(input logic [FRAME_W-1:0] frame);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (sender_idles)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(0, 20);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid        = 1'b1;
        s_frame_number = frame;
        do @(posedge aclk); while (!s_ready);
        pending_jitter.push_back(jitter_for_frame(frame));
        pending_frame.push_back(frame);
    endtask

    // hold the sender until every pending result is back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_jitter.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_extent(input logic [REG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we      = 1'b1;
        cfg_index   = idx;
        cfg_wdata   = EXT_W'(value);
        extent[idx] = EXT_W'(value);
    endtask

    task automatic set_extents(input int rw, input int rh, input int ow, input int oh);
        wait_results_drained();
        write_extent(hsjg_pkg::REG_RENDER_WIDTH, rw);
        write_extent(hsjg_pkg::REG_RENDER_HEIGHT, rh);
        write_extent(hsjg_pkg::REG_OUTPUT_WIDTH, ow);
        write_extent(hsjg_pkg::REG_OUTPUT_HEIGHT, oh);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // extents are all zero out of reset
    task automatic test_reset_state();
        send_frame('0);
        send_frame('1);
    endtask

    // 2^31 phases: saturation of both jitters, most negative jitter, wrap of the cycle
    task automatic test_longest_cycle();
        set_extents(1, 1, MAX_EXTENT, MAX_EXTENT);
        send_frame(64'd0);
        send_frame(64'd131070);
        send_frame(64'd177145);
        send_frame(64'h0000_0000_3FFF_FFFF);
        send_frame(64'h0000_0000_7FFF_FFFF);
        send_frame(64'h0000_0000_8000_0000);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    // downscale: phase count floors at the minimum, walk the full cycle and wrap
    task automatic test_shortest_cycle();
        set_extents(MAX_EXTENT, MAX_EXTENT, 1, 1);
        for (int f = 0; f <= MIN_PHASES; f++)
            send_frame(64'(f));
    endtask

    // each extent zero in turn, and extents above the maximum
    task automatic test_invalid_extents();
        set_extents(0, 1080, 3840, 2160);
        send_frame(64'd5);
        set_extents(1920, 0, 3840, 2160);
        send_frame(64'd5);
        set_extents(1920, 1080, 0, 2160);
        send_frame(64'd5);
        set_extents(1920, 1080, 3840, 0);
        send_frame(64'd5);
        set_extents(MAX_EXTENT + 1, 1080, 3840, 2160);
        send_frame(64'd5);
        set_extents(1920, 1080, 3840, EXTENT_ALL_ONES);
        send_frame(64'd5);
    endtask

    // random settings, each followed by a run of random frames
    task automatic test_random_settings();
        int sent, setting, n;
        sent    = 0;
        setting = 0;
        while (sent < RANDOM_ITEMS) begin
            set_extents(pick_extent(), pick_extent(), pick_extent(), pick_extent());
            sender_idles = (setting % 4 != 3);
            n = $urandom_range(15, 60);
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && setting % 3 == 0)
                    wait_results_drained();
                send_frame(pick_frame());
                sent++;
            end
            setting++;
        end
        sender_idles = 1'b1;
    endtask

    // ---------------------------------------------------------------- result side

    // receiver stall pattern: long ready runs, long stalls, toggling, coin flips
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = (ready_mode == 0) ? $urandom_range(50, 400) : $urandom_range(1, 60);
        end
        ready_left--;
        case (ready_mode)
            0:       m_ready = 1'b1;
            1:       m_ready = 1'b0;
            2:       m_ready = ready_left[0];
            default: m_ready = 1'($urandom_range(0, 1));
        endcase
    end

    // compare each result transaction with the oldest pending prediction
    always @(posedge aclk) begin : check_results
        jitter_result_t want;
        logic [FRAME_W-1:0] fr;
        if (aresetn && m_valid && m_ready) begin
            if (pending_jitter.size() == 0) begin
                report_mismatch("result transaction with no frame pending");
            end else begin
                want = pending_jitter.pop_front();
                fr   = pending_frame.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("frame %h status: expected %0d, got %0d",
                                              fr, want.status, m_status));
                if (m_jitter_x !== want.jitter_x)
                    report_mismatch($sformatf("frame %h jitter_x: expected %0d, got %0d",
                                              fr, want.jitter_x, m_jitter_x));
                if (m_jitter_y !== want.jitter_y)
                    report_mismatch($sformatf("frame %h jitter_y: expected %0d, got %0d",
                                              fr, want.jitter_y, m_jitter_y));
                if (m_offset_x !== want.offset_x)
                    report_mismatch($sformatf("frame %h offset_x: expected %0d, got %0d",
                                              fr, want.offset_x, m_offset_x));
                if (m_offset_y !== want.offset_y)
                    report_mismatch($sformatf("frame %h offset_y: expected %0d, got %0d",
                                              fr, want.offset_y, m_offset_y));
                if (m_phase_count !== want.phase_count)
                    report_mismatch($sformatf("frame %h phase_count: expected %0d, got %0d",
                                              fr, want.phase_count, m_phase_count));
                if (m_phase_index !== want.phase_index)
                    report_mismatch($sformatf("frame %h phase_index: expected %0d, got %0d",
                                              fr, want.phase_index, m_phase_index));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = hsjg_pkg::REG_RENDER_WIDTH;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_frame_number = '0;
        foreach (extent[i])
            extent[i] = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_longest_cycle();
        test_shortest_cycle();
        test_invalid_extents();
        test_random_settings();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_jitter.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
